// ===== design/tcgr_pkg.sv =====
package tcgr_pkg;

  // Input modes.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_PRINT = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_ROW    = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Operations queued between front and back.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_GLYPH  = 2'd1;
  localparam logic [1:0] OP_SCROLL = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FG_COLOR     = 2'd0;
  localparam logic [1:0] REG_BG_COLOR     = 2'd1;
  localparam logic [1:0] REG_TEXT_COLUMNS = 2'd2;
  localparam logic [1:0] REG_TEXT_ROWS    = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  // Tab stops every 4 columns, so the remainder is the low two bits.
  localparam int TAB_BITS = 2;

  localparam int FONT_DEPTH = 4096;
  localparam int FONT_AW    = 12;
  localparam int PIX_W      = 11;

  localparam logic [31:0] FG_RESET   = 32'd11184810;
  localparam logic [31:0] BG_RESET   = 32'd0;
  localparam logic [7:0]  COLS_RESET = 8'd80;
  localparam logic [6:0]  ROWS_RESET = 7'd25;

  // One queued operation. For a font load, addr/data are the write; for a
  // glyph, addr is the first font row address and px/py the cell origin.
  typedef struct packed {
    logic [1:0]         op;
    logic [FONT_AW-1:0] addr;
    logic [7:0]         data;
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic               scroll;
  } cmd_t;

endpackage

// ===== design/tcgr_ram.sv =====
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tcgr_fifo.sv =====
module tcgr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcgr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output tcgr_pkg::cmd_t pop_data,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tcgr_pkg::cmd_t  slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/tcgr_front.sv =====
module tcgr_front #(
  parameter int FONT_HEIGHT = 16,
  parameter int FONT_WIDTH  = 8,
  parameter int GLYPH_COUNT = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_mode,
  input  logic [7:0]     in_char_code,
  input  logic [11:0]    in_font_address,
  input  logic [7:0]     in_font_byte,
  input  logic [7:0]     text_columns,
  input  logic [6:0]     text_rows,
  output logic           push,
  output tcgr_pkg::cmd_t push_data,
  input  logic           full
);

  localparam int TAB_W_LOCAL = tcgr_pkg::TAB_BITS;

  logic [7:0] cur_col_r, cur_col_nxt;
  logic [6:0] cur_row_r, cur_row_nxt;
  logic [7:0] glyph_lut [256];
  logic [7:0] cols, rows;
  logic [8:0] col_w;
  logic [7:0] row_w;
  logic [TAB_W_LOCAL-1:0] tab_add;
  logic       accept, is_glyph, scroll;

  // Character code modulo the glyph count, folded at elaboration.
  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign glyph_lut[g] = 8'(g % GLYPH_COUNT);
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign cols     = (text_columns == 8'd0) ? 8'd1 : text_columns;
  assign rows     = (text_rows == 7'd0) ? 8'd1 : {1'b0, text_rows};
  assign tab_add  = TAB_W_LOCAL'(0) - cur_col_r[TAB_W_LOCAL-1:0];
  assign is_glyph = (in_char_code != tcgr_pkg::CH_NEWLINE) &&
                    (in_char_code != tcgr_pkg::CH_TAB);

  always_comb begin
    col_w = {1'b0, cur_col_r};
    row_w = {1'b0, cur_row_r};
    if (in_char_code == tcgr_pkg::CH_NEWLINE) begin
      col_w = 9'd0;
      row_w = row_w + 8'd1;
    end else if (in_char_code == tcgr_pkg::CH_TAB) begin
      col_w = col_w + 9'(tab_add);
    end else begin
      col_w = col_w + 9'd1;
    end
    if (col_w >= {1'b0, cols}) begin
      col_w = 9'd0;
      row_w = row_w + 8'd1;
    end
    scroll = (row_w >= rows);
    if (scroll) begin
      row_w = rows - 8'd1;
    end
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    push        = 1'b0;
    push_data.op     = tcgr_pkg::OP_LOAD;
    push_data.addr   = in_font_address;
    push_data.data   = in_font_byte;
    push_data.px     = 11'({3'd0, cur_col_r} * 11'(FONT_WIDTH));
    push_data.py     = 11'({4'd0, cur_row_r} * 11'(FONT_HEIGHT));
    push_data.scroll = scroll;
    case (in_mode)
      tcgr_pkg::MODE_LOAD: begin
        push = accept;
      end
      tcgr_pkg::MODE_CLEAR: begin
        push         = accept;
        push_data.op = tcgr_pkg::OP_CLEAR;
        if (accept) begin
          cur_col_nxt = 8'd0;
          cur_row_nxt = 7'd0;
        end
      end
      tcgr_pkg::MODE_PRINT: begin
        if (is_glyph) begin
          push           = accept;
          push_data.op   = tcgr_pkg::OP_GLYPH;
          push_data.addr = 12'({4'd0, glyph_lut[in_char_code]} * 12'(FONT_HEIGHT));
        end else begin
          push         = accept && scroll;
          push_data.op = tcgr_pkg::OP_SCROLL;
        end
        if (accept) begin
          cur_col_nxt = col_w[7:0];
          cur_row_nxt = row_w[6:0];
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= 8'd0;
      cur_row_r <= 7'd0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

endmodule

// ===== design/tcgr_back.sv =====
module tcgr_back #(
  parameter int FONT_HEIGHT = 16,
  parameter int FONT_WIDTH  = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tcgr_pkg::cmd_t cmd,
  input  logic           empty,
  output logic           pop,
  input  logic [31:0]    fg_color,
  input  logic [31:0]    bg_color,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [10:0]    out_pixel_x,
  output logic [10:0]    out_pixel_y,
  output logic [7:0]     out_row_bits,
  output logic [31:0]    out_fore_color,
  output logic [31:0]    out_back_color,
  output logic           out_last
);

  localparam int CW = $clog2(FONT_HEIGHT + 1);
  localparam logic [7:0] ROW_MASK = 8'((16'hFF << (8 - FONT_WIDTH)) & 16'hFF);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GLYPH  = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic        dv_r, dv_nxt;
  logic        ov_r, ov_nxt;
  logic [11:0] base_r;
  logic [10:0] px_r, py_r;
  logic        scroll_r;

  logic [1:0]  kind_r;
  logic [10:0] ox_r, oy_r;
  logic [7:0]  bits_r;
  logic [31:0] fore_r, back_r;
  logic        last_r;

  logic        out_free, issue, load_row, load_cmd, load_scroll, last_row;
  logic        ram_we;
  logic [7:0]  ram_q;

  assign out_free  = !ov_r || out_ready;
  assign load_row  = (st_r == ST_GLYPH) && dv_r && out_free;
  assign issue     = (st_r == ST_GLYPH) && (iss_r != CW'(FONT_HEIGHT)) &&
                     (!dv_r || load_row);
  assign last_row  = (emit_r == CW'(FONT_HEIGHT - 1));
  assign pop       = (st_r == ST_IDLE) && !empty &&
                     ((cmd.op == tcgr_pkg::OP_LOAD) || (cmd.op == tcgr_pkg::OP_GLYPH) ||
                      out_free);
  assign ram_we    = pop && (cmd.op == tcgr_pkg::OP_LOAD);
  assign load_cmd  = pop && ((cmd.op == tcgr_pkg::OP_SCROLL) ||
                             (cmd.op == tcgr_pkg::OP_CLEAR));
  assign load_scroll = (st_r == ST_SCROLL) && out_free;

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (tcgr_pkg::FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.addr),
    .wdata (cmd.data),
    .re    (issue),
    .raddr (base_r + 12'(iss_r)),
    .rdata (ram_q)
  );

  always_comb begin
    st_nxt   = st_r;
    iss_nxt  = iss_r;
    emit_nxt = emit_r;
    dv_nxt   = dv_r;
    case (st_r)
      ST_IDLE: begin
        if (pop && (cmd.op == tcgr_pkg::OP_GLYPH)) begin
          st_nxt   = ST_GLYPH;
          iss_nxt  = '0;
          emit_nxt = '0;
          dv_nxt   = 1'b0;
        end
      end
      ST_GLYPH: begin
        if (issue) begin
          iss_nxt = iss_r + CW'(1);
          dv_nxt  = 1'b1;
        end else if (load_row) begin
          dv_nxt  = 1'b0;
        end
        if (load_row) begin
          emit_nxt = emit_r + CW'(1);
          if (last_row) begin
            st_nxt = scroll_r ? ST_SCROLL : ST_IDLE;
          end
        end
      end
      ST_SCROLL: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (out_free) begin
      ov_nxt = load_row || load_cmd || load_scroll;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      iss_r  <= '0;
      emit_r <= '0;
      dv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      iss_r  <= iss_nxt;
      emit_r <= emit_nxt;
      dv_r   <= dv_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (cmd.op == tcgr_pkg::OP_GLYPH)) begin
      base_r   <= cmd.addr;
      px_r     <= cmd.px;
      py_r     <= cmd.py;
      scroll_r <= cmd.scroll;
    end
    if (load_row) begin
      kind_r <= tcgr_pkg::KIND_ROW;
      ox_r   <= px_r;
      oy_r   <= py_r + 11'(emit_r);
      bits_r <= ram_q & ROW_MASK;
      fore_r <= fg_color;
      back_r <= bg_color;
      last_r <= last_row && !scroll_r;
    end else if (load_cmd || load_scroll) begin
      kind_r <= (load_cmd && (cmd.op == tcgr_pkg::OP_CLEAR)) ?
                tcgr_pkg::KIND_CLEAR : tcgr_pkg::KIND_SCROLL;
      ox_r   <= 11'd0;
      oy_r   <= 11'd0;
      bits_r <= 8'd0;
      fore_r <= 32'd0;
      back_r <= bg_color;
      last_r <= 1'b1;
    end
  end

  assign out_valid      = ov_r;
  assign out_kind       = kind_r;
  assign out_pixel_x    = ox_r;
  assign out_pixel_y    = oy_r;
  assign out_row_bits   = bits_r;
  assign out_fore_color = fore_r;
  assign out_back_color = back_r;
  assign out_last       = last_r;

endmodule

// ===== design/text_console_glyph_renderer_unit.sv =====
// Channel   Ports                                            Direction
// in        in_valid/in_ready, mode, char_code, font_*       request into the block
// out       out_valid/out_ready, kind, pixel_*, colors, last  command out of the block
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data         register write into the block
//
// The front takes one request per cycle while the command queue has room; it
// updates the cursor at once and queues at most one operation per request.
// In the back, a printed glyph is dequeued and its font rows are read, then one
// row command goes out per cycle while the output is not stalled, plus a
// trailing scroll command if it scrolls. A font load is written when dequeued.
// Reset is synchronous and active low; it homes the cursor and restores the
// register defaults. The font memory is not cleared. Output stalls hold the
// back, and the queue lets the front keep accepting until it fills.
module text_console_glyph_renderer_unit #(
  parameter int FONT_HEIGHT = 16,
  parameter int FONT_WIDTH  = 8,
  parameter int GLYPH_COUNT = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [11:0] in_font_address,
  input  logic [7:0]  in_font_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [10:0] out_pixel_x,
  output logic [10:0] out_pixel_y,
  output logic [7:0]  out_row_bits,
  output logic [31:0] out_fore_color,
  output logic [31:0] out_back_color,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] fg_color_r, bg_color_r;
  logic [7:0]  text_columns_r;
  logic [6:0]  text_rows_r;

  tcgr_pkg::cmd_t push_data, head;
  logic           push, full, pop, empty;

  // Always ready; user must write registers only while the block idles; unenforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r     <= tcgr_pkg::FG_RESET;
      bg_color_r     <= tcgr_pkg::BG_RESET;
      text_columns_r <= tcgr_pkg::COLS_RESET;
      text_rows_r    <= tcgr_pkg::ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcgr_pkg::REG_FG_COLOR:     fg_color_r     <= cfg_data;
        tcgr_pkg::REG_BG_COLOR:     bg_color_r     <= cfg_data;
        tcgr_pkg::REG_TEXT_COLUMNS: text_columns_r <= cfg_data[7:0];
        tcgr_pkg::REG_TEXT_ROWS:    text_rows_r    <= cfg_data[6:0];
        default: begin
          fg_color_r <= fg_color_r;
        end
      endcase
    end
  end

  // The front owns the cursor and decides what each request turns into.
  tcgr_front #(
    .FONT_HEIGHT (FONT_HEIGHT),
    .FONT_WIDTH  (FONT_WIDTH),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_char_code    (in_char_code),
    .in_font_address (in_font_address),
    .in_font_byte    (in_font_byte),
    .text_columns    (text_columns_r),
    .text_rows       (text_rows_r),
    .push            (push),
    .push_data       (push_data),
    .full            (full)
  );

  // Font loads travel through the queue too, so they stay ordered with
  // the glyph reads that come before them.
  tcgr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  // The back holds the font memory and streams the row commands.
  tcgr_back #(
    .FONT_HEIGHT (FONT_HEIGHT),
    .FONT_WIDTH  (FONT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (head),
    .empty          (empty),
    .pop            (pop),
    .fg_color       (fg_color_r),
    .bg_color       (bg_color_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_row_bits   (out_row_bits),
    .out_fore_color (out_fore_color),
    .out_back_color (out_back_color),
    .out_last       (out_last)
  );

endmodule
